[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");

`endif

[rtl/core/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Types and constants shared by the servo command parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scp_pkg;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_PAN     = 3'd1,
		KIND_TILT    = 3'd2,
		KIND_PANTILT = 3'd3,
		KIND_REJECT  = 3'd4,
		KIND_CENTER  = 3'd5,
		KIND_STOP    = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        first_neg;
		logic [11:0] first_scaled;
		logic        second_neg;
		logic [11:0] second_scaled;
	} cmd_t;

	localparam logic [11:0] PULSE_CENTER = 12'd1500;
	localparam logic [6:0]  ANGLE_LIMIT  = 7'd60;
	localparam logic [6:0]  MAG_SAT      = 7'd127;
	localparam logic [11:0] ANGLE_SCALE  = 12'd50;
	localparam logic [15:0] RECIP_THREE  = 16'd43691;

	localparam logic [4:0] MS_START       = 5'd0;
	localparam logic [4:0] MS_P           = 5'd1;
	localparam logic [4:0] MS_PA          = 5'd2;
	localparam logic [4:0] MS_PAN         = 5'd3;
	localparam logic [4:0] MS_PAN_NUM     = 5'd4;
	localparam logic [4:0] MS_PANT        = 5'd5;
	localparam logic [4:0] MS_PANTI       = 5'd6;
	localparam logic [4:0] MS_PANTIL      = 5'd7;
	localparam logic [4:0] MS_PANTILT     = 5'd8;
	localparam logic [4:0] MS_PANTILT_NUM = 5'd9;
	localparam logic [4:0] MS_T           = 5'd10;
	localparam logic [4:0] MS_TI          = 5'd11;
	localparam logic [4:0] MS_TIL         = 5'd12;
	localparam logic [4:0] MS_TILT        = 5'd13;
	localparam logic [4:0] MS_TILT_NUM    = 5'd14;
	localparam logic [4:0] MS_C           = 5'd15;
	localparam logic [4:0] MS_CE          = 5'd16;
	localparam logic [4:0] MS_CEN         = 5'd17;
	localparam logic [4:0] MS_CENT        = 5'd18;
	localparam logic [4:0] MS_CENTE       = 5'd19;
	localparam logic [4:0] MS_CENTER_DONE = 5'd20;
	localparam logic [4:0] MS_S           = 5'd21;
	localparam logic [4:0] MS_ST          = 5'd22;
	localparam logic [4:0] MS_STO         = 5'd23;
	localparam logic [4:0] MS_STOP_DONE   = 5'd24;
	localparam logic [4:0] MS_DEAD        = 5'd25;

	localparam logic [2:0] PH_FIRST_WAIT    = 3'd0;
	localparam logic [2:0] PH_FIRST_SIGN    = 3'd1;
	localparam logic [2:0] PH_FIRST_DIGITS  = 3'd2;
	localparam logic [2:0] PH_SECOND_WAIT   = 3'd4;
	localparam logic [2:0] PH_SECOND_SIGN   = 3'd5;
	localparam logic [2:0] PH_SECOND_DIGITS = 3'd6;
	localparam logic [2:0] PH_DONE          = 3'd7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_T     = 8'h54;

endpackage

[rtl/core/scp_front.sv]
// ----------------------------------------------------------------------------
// scp_front
// Per-byte command matcher and number reader; emits one command at message end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_front #(
	parameter int MSG_CAPACITY = 99
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              action,
	input  logic [7:0]        data_byte,
	output logic              push,
	output scp_pkg::cmd_t     push_cmd
);
	import scp_pkg::*;

	localparam logic [6:0] CAPACITY = 7'(MSG_CAPACITY);

	logic [6:0] byte_count_q;
	logic       line_ended_q;
	logic [4:0] match_q;
	logic [2:0] phase_q;
	logic       first_neg_q;
	logic [6:0] first_mag_q;
	logic       first_has_q;
	logic       second_neg_q;
	logic [6:0] second_mag_q;
	logic       second_has_q;

	logic [2:0] phase_d;
	logic       first_neg_d;
	logic [6:0] first_mag_d;
	logic       first_has_d;
	logic       second_neg_d;
	logic [6:0] second_mag_d;
	logic       second_has_d;

	logic       take_byte;
	logic       is_end_char;
	logic       in_number;
	logic       two_numbers;
	logic       blank;
	logic       digit;
	logic       sign;
	logic [6:0] first_clamp;
	logic [6:0] second_clamp;

	function automatic logic [6:0] add_digit(input logic [6:0] mag, input logic [7:0] c);
		logic [10:0] v;
		v = 11'(mag) * 11'd10 + 11'(c[3:0]);
		return (v > 11'(MAG_SAT)) ? MAG_SAT : v[6:0];
	endfunction

	function automatic logic [4:0] next_match(input logic [4:0] s, input logic [7:0] c);
		logic [4:0] n;
		n = MS_DEAD;
		case (s)
			MS_START: begin
				if (c == CH_P) n = MS_P;
				else if (c == CH_T) n = MS_T;
				else if (c == CH_C) n = MS_C;
				else if (c == CH_S) n = MS_S;
			end
			MS_P:       if (c == CH_A) n = MS_PA;
			MS_PA:      if (c == CH_N) n = MS_PAN;
			MS_PAN: begin
				if (c == CH_COLON) n = MS_PAN_NUM;
				else if (c == CH_T) n = MS_PANT;
			end
			MS_PANT:    if (c == CH_I) n = MS_PANTI;
			MS_PANTI:   if (c == CH_L) n = MS_PANTIL;
			MS_PANTIL:  if (c == CH_T) n = MS_PANTILT;
			MS_PANTILT: if (c == CH_COLON) n = MS_PANTILT_NUM;
			MS_T:       if (c == CH_I) n = MS_TI;
			MS_TI:      if (c == CH_L) n = MS_TIL;
			MS_TIL:     if (c == CH_T) n = MS_TILT;
			MS_TILT:    if (c == CH_COLON) n = MS_TILT_NUM;
			MS_C:       if (c == CH_E) n = MS_CE;
			MS_CE:      if (c == CH_N) n = MS_CEN;
			MS_CEN:     if (c == CH_T) n = MS_CENT;
			MS_CENT:    if (c == CH_E) n = MS_CENTE;
			MS_CENTE:   if (c == CH_R) n = MS_CENTER_DONE;
			MS_S:       if (c == CH_T) n = MS_ST;
			MS_ST:      if (c == CH_O) n = MS_STO;
			MS_STO:     if (c == CH_P) n = MS_STOP_DONE;
			default:    n = MS_DEAD;
		endcase
		return n;
	endfunction

	assign take_byte   = accept && !action && !line_ended_q && (byte_count_q < CAPACITY);
	assign is_end_char = (data_byte == CH_NUL) || (data_byte == CH_LF) || (data_byte == CH_CR);
	assign two_numbers = (match_q == MS_PANTILT_NUM);
	assign in_number   = (match_q == MS_PAN_NUM) || (match_q == MS_TILT_NUM) || two_numbers;
	assign blank       = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
	                     (data_byte == CH_VT) || (data_byte == CH_FF);
	assign digit       = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign sign        = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);

	always_comb begin
		phase_d      = phase_q;
		first_neg_d  = first_neg_q;
		first_mag_d  = first_mag_q;
		first_has_d  = first_has_q;
		second_neg_d = second_neg_q;
		second_mag_d = second_mag_q;
		second_has_d = second_has_q;
		case (phase_q)
			PH_FIRST_WAIT: begin
				if (blank) begin
					phase_d = phase_q;
				end else if (sign) begin
					first_neg_d = (data_byte == CH_MINUS);
					phase_d     = PH_FIRST_SIGN;
				end else if (digit) begin
					first_mag_d = add_digit(first_mag_q, data_byte);
					first_has_d = 1'b1;
					phase_d     = PH_FIRST_DIGITS;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_FIRST_SIGN, PH_FIRST_DIGITS: begin
				if (digit) begin
					first_mag_d = add_digit(first_mag_q, data_byte);
					first_has_d = 1'b1;
					phase_d     = PH_FIRST_DIGITS;
				end else if (two_numbers && (phase_q == PH_FIRST_DIGITS) &&
				             (data_byte == CH_COMMA)) begin
					phase_d = PH_SECOND_WAIT;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_SECOND_WAIT: begin
				if (blank) begin
					phase_d = phase_q;
				end else if (sign) begin
					second_neg_d = (data_byte == CH_MINUS);
					phase_d      = PH_SECOND_SIGN;
				end else if (digit) begin
					second_mag_d = add_digit(second_mag_q, data_byte);
					second_has_d = 1'b1;
					phase_d      = PH_SECOND_DIGITS;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_SECOND_SIGN, PH_SECOND_DIGITS: begin
				if (digit) begin
					second_mag_d = add_digit(second_mag_q, data_byte);
					second_has_d = 1'b1;
					phase_d      = PH_SECOND_DIGITS;
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: phase_d = PH_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			line_ended_q <= 1'b0;
			match_q      <= MS_START;
			phase_q      <= PH_FIRST_WAIT;
			first_neg_q  <= 1'b0;
			first_mag_q  <= '0;
			first_has_q  <= 1'b0;
			second_neg_q <= 1'b0;
			second_mag_q <= '0;
			second_has_q <= 1'b0;
		end else if (accept && action) begin
			byte_count_q <= '0;
			line_ended_q <= 1'b0;
			match_q      <= MS_START;
			phase_q      <= PH_FIRST_WAIT;
			first_neg_q  <= 1'b0;
			first_mag_q  <= '0;
			first_has_q  <= 1'b0;
			second_neg_q <= 1'b0;
			second_mag_q <= '0;
			second_has_q <= 1'b0;
		end else if (take_byte) begin
			byte_count_q <= byte_count_q + 7'd1;
			if (is_end_char) begin
				line_ended_q <= 1'b1;
			end else if (in_number) begin
				phase_q      <= phase_d;
				first_neg_q  <= first_neg_d;
				first_mag_q  <= first_mag_d;
				first_has_q  <= first_has_d;
				second_neg_q <= second_neg_d;
				second_mag_q <= second_mag_d;
				second_has_q <= second_has_d;
			end else begin
				match_q <= next_match(match_q, data_byte);
			end
		end
	end

	assign first_clamp  = (first_mag_q > ANGLE_LIMIT) ? ANGLE_LIMIT : first_mag_q;
	assign second_clamp = (second_mag_q > ANGLE_LIMIT) ? ANGLE_LIMIT : second_mag_q;

	always_comb begin
		push_cmd.first_neg     = first_neg_q;
		push_cmd.first_scaled  = 12'(first_clamp) * ANGLE_SCALE;
		push_cmd.second_neg    = second_neg_q;
		push_cmd.second_scaled = 12'(second_clamp) * ANGLE_SCALE;
		case (match_q)
			MS_PAN_NUM:     push_cmd.kind = KIND_PAN;
			MS_TILT_NUM:    push_cmd.kind = KIND_TILT;
			MS_PANTILT_NUM: push_cmd.kind = (first_has_q && second_has_q) ?
			                                KIND_PANTILT : KIND_REJECT;
			MS_CENTER_DONE: push_cmd.kind = KIND_CENTER;
			MS_STOP_DONE:   push_cmd.kind = KIND_STOP;
			default:        push_cmd.kind = KIND_NONE;
		endcase
	end

	assign push = accept && action;

endmodule

[rtl/core/scp_queue.sv]
// ----------------------------------------------------------------------------
// scp_queue
// Two-entry command queue between the parser and the executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  scp_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          head_valid,
	output scp_pkg::cmd_t head_cmd,
	output logic          full
);
	import scp_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign full       = (count_q == 2'(DEPTH));

endmodule

[rtl/core/scp_back.sv]
// ----------------------------------------------------------------------------
// scp_back
// Command executor: pulse registers, angle-to-pulse scaling and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  scp_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [11:0]   pan_pulse,
	output logic [11:0]   tilt_pulse,
	output logic [2:0]    command_kind
);
	import scp_pkg::*;

	logic [11:0] pan_reg_q;
	logic [11:0] tilt_reg_q;
	logic        out_valid_q;
	logic [11:0] pan_out_q;
	logic [11:0] tilt_out_q;
	kind_t       kind_out_q;

	logic [27:0] first_prod;
	logic [27:0] second_prod;
	logic [11:0] first_pulse;
	logic [11:0] second_pulse;
	logic [11:0] pan_next;
	logic [11:0] tilt_next;

	assign pop = head_valid && (!out_valid_q || !out_stall);

	assign first_prod  = 28'(head_cmd.first_scaled) * 28'(RECIP_THREE);
	assign second_prod = 28'(head_cmd.second_scaled) * 28'(RECIP_THREE);

	assign first_pulse  = head_cmd.first_neg ? PULSE_CENTER - 12'(first_prod[26:17]) :
	                                           PULSE_CENTER + 12'(first_prod[26:17]);
	assign second_pulse = head_cmd.second_neg ? PULSE_CENTER - 12'(second_prod[26:17]) :
	                                            PULSE_CENTER + 12'(second_prod[26:17]);

	always_comb begin
		pan_next  = pan_reg_q;
		tilt_next = tilt_reg_q;
		unique case (head_cmd.kind)
			KIND_PAN:     pan_next = first_pulse;
			KIND_TILT:    tilt_next = first_pulse;
			KIND_PANTILT: begin
				pan_next  = first_pulse;
				tilt_next = second_pulse;
			end
			KIND_CENTER, KIND_STOP: begin
				pan_next  = PULSE_CENTER;
				tilt_next = PULSE_CENTER;
			end
			default: begin
				pan_next  = pan_reg_q;
				tilt_next = tilt_reg_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_reg_q   <= PULSE_CENTER;
			tilt_reg_q  <= PULSE_CENTER;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pan_reg_q  <= pan_next;
				tilt_reg_q <= tilt_next;
			end
			if (pop) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pan_out_q  <= pan_next;
			tilt_out_q <= tilt_next;
			kind_out_q <= head_cmd.kind;
		end
	end

	assign out_valid    = out_valid_q;
	assign pan_pulse    = pan_out_q;
	assign tilt_pulse   = tilt_out_q;
	assign command_kind = kind_out_q;

endmodule

[rtl/core/servo_command_parser_core.sv]
// ----------------------------------------------------------------------------
// servo_command_parser_core
// Byte-serial servo command parser with pan and tilt pulse registers.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low: a message byte or
// an end-of-message mark. Bytes are matched and their numbers read as they
// arrive. An end-of-message item puts the finished command into a two-entry
// queue; the executor takes it from the queue, updates the pulse registers and
// loads the result into its output register, unless an earlier result is still
// held by the output side.
// in_stall rises only while the queue holds two commands, which happens when
// the output side holds results back.
`timescale 1ns / 1ps

module servo_command_parser_core #(
	parameter int MSG_CAPACITY = 99
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] pan_pulse,
	output logic [11:0] tilt_pulse,
	output logic [2:0]  command_kind
);
	import scp_pkg::*;

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;
	logic full;

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	scp_front #(
		.MSG_CAPACITY(MSG_CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (action),
		.data_byte(data_byte),
		.push     (push),
		.push_cmd (push_cmd)
	);

	scp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.full      (full)
	);

	scp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pan_pulse   (pan_pulse),
		.tilt_pulse  (tilt_pulse),
		.command_kind(command_kind)
	);

endmodule

[rtl/core/scp_checker.sv]
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks on the servo command parser results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] pan_pulse,
	input logic [11:0] tilt_pulse,
	input logic [2:0]  command_kind
);
	import scp_pkg::*;

	logic centered;
	logic in_range;

	assign centered = (pan_pulse == PULSE_CENTER) && (tilt_pulse == PULSE_CENTER);
	assign in_range = (pan_pulse >= 12'd500) && (pan_pulse <= 12'd2500) &&
	                  (tilt_pulse >= 12'd500) && (tilt_pulse <= 12'd2500);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(pan_pulse) && $stable(tilt_pulse) && $stable(command_kind))
	`ASSERT_IMPL(a_center_stop, clk, arst_n, out_valid && ((command_kind == KIND_CENTER) || (command_kind == KIND_STOP)), centered)
	`ASSERT_IMPL(a_pulse_range, clk, arst_n, out_valid, in_range)
	`ASSERT_IMPL(a_stall_holds_result, clk, arst_n, in_valid && in_stall, out_valid)

endmodule

bind servo_command_parser_core scp_checker u_scp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pan_pulse   (pan_pulse),
	.tilt_pulse  (tilt_pulse),
	.command_kind(command_kind)
);
